[rtl/spd_pkg.sv]
// Package for the sensor packet deframer: codes, constants and the result record.
// No dependencies; used by the channel interfaces and every module in rtl/.
package spd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LenW     = 10;

  localparam logic [CfgIdxW-1:0] CFG_DEADLINE_MS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd1;

  localparam logic [15:0]     TimeoutReset    = 16'd2000;
  localparam logic [LenW-1:0] MaxPayloadReset = 10'd64;
  localparam logic [15:0]     HdrSync         = 16'hEF01;
  localparam logic [3:0]      HdrLastPos      = 4'd8;
  localparam logic [3:0]      HdrKindPos      = 4'd6;
  localparam logic [3:0]      HdrLenHiPos     = 4'd7;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CK_HIGH = 3'd3,
    PH_CK_LOW  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HDR  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_CK_BAD   = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t      item_kind;
    logic [7:0]      payload_byte;
    logic [LenW-1:0] byte_index;
    status_t         status;
    logic [7:0]      packet_kind;
    logic [LenW-1:0] payload_length;
  } result_t;

endpackage

[rtl/spd_item_if.sv]
// Input request channel of the deframer: valid/ready plus opcode and byte.
// Depends on spd_pkg.
interface spd_item_if
  import spd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink (input valid, input opcode, input byte_value, output ready);
endinterface

[rtl/spd_result_if.sv]
// Result request channel of the deframer: valid/ready plus the result fields.
// Depends on spd_pkg.
interface spd_result_if
  import spd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            item_kind;
  logic [7:0]      payload_byte;
  logic [LenW-1:0] byte_index;
  logic [2:0]      status;
  logic [7:0]      packet_kind;
  logic [LenW-1:0] payload_length;

  modport source (
    output valid, output item_kind, output payload_byte, output byte_index,
    output status, output packet_kind, output payload_length, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input byte_index,
    input status, input packet_kind, input payload_length, output ready
  );
endinterface

[rtl/spd_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
// Depends on spd_pkg and spd_result_if.
module spd_out_buf
  import spd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  result_t         push_data,
  output logic            space,
  spd_result_if.source    result
);

  logic    main_valid;
  logic    skid_valid;
  result_t main;
  result_t skid;
  logic    pop;

  assign pop   = main_valid && result.ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      if (skid_valid) begin
        main       <= skid;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main       <= push_data;
        main_valid <= push;
      end
    end else if (push) begin
      skid       <= push_data;
      skid_valid <= 1'b1;
    end
  end

  assign result.valid          = main_valid;
  assign result.item_kind      = main.item_kind;
  assign result.payload_byte   = main.payload_byte;
  assign result.byte_index     = main.byte_index;
  assign result.status         = main.status;
  assign result.packet_kind    = main.packet_kind;
  assign result.payload_length = main.payload_length;

endmodule

[rtl/spd_core.sv]
// Deframer state machine: header check, payload tagging, checksum, deadline.
// Depends on spd_pkg and spd_item_if; holds the two configuration registers.
module spd_core
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                space,
  spd_item_if.sink            item,
  output logic                push,
  output result_t             push_data
);

  logic [15:0]     deadline_ms;
  logic [LenW-1:0] max_payload;

  phase_t          phase, phase_next;
  logic [LenW-1:0] position, position_next;
  logic [15:0]     header_first_bytes, header_first_bytes_next;
  logic [7:0]      kind_byte, kind_byte_next;
  logic [15:0]     length_field, length_field_next;
  logic [15:0]     running_sum, running_sum_next;
  logic [7:0]      checksum_high, checksum_high_next;
  logic [15:0]     time_left, time_left_next;
  logic [LenW-1:0] accepted_len, accepted_len_next;

  logic            take;
  logic [15:0]     len_full;
  logic [15:0]     len_pay;
  logic [LenW-1:0] pos_inc;
  logic [3:0]      hpos;

  assign item.ready = space;
  assign take       = item.valid && item.ready;
  assign len_full   = {length_field[7:0], item.byte_value};
  assign len_pay    = len_full - 16'd2;
  assign pos_inc    = position + LenW'(1);
  assign hpos       = position[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_ms <= TimeoutReset;
      max_payload <= MaxPayloadReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEADLINE_MS: deadline_ms <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      position           <= '0;
      header_first_bytes <= '0;
      kind_byte          <= '0;
      length_field       <= '0;
      running_sum        <= '0;
      checksum_high      <= '0;
      time_left          <= '0;
      accepted_len       <= '0;
    end else begin
      phase              <= phase_next;
      position           <= position_next;
      header_first_bytes <= header_first_bytes_next;
      kind_byte          <= kind_byte_next;
      length_field       <= length_field_next;
      running_sum        <= running_sum_next;
      checksum_high      <= checksum_high_next;
      time_left          <= time_left_next;
      accepted_len       <= accepted_len_next;
    end
  end

  always_comb begin
    phase_next              = phase;
    position_next           = position;
    header_first_bytes_next = header_first_bytes;
    kind_byte_next          = kind_byte;
    length_field_next       = length_field;
    running_sum_next        = running_sum;
    checksum_high_next      = checksum_high;
    time_left_next          = time_left;
    accepted_len_next       = accepted_len;
    push                    = 1'b0;
    push_data               = '0;
    push_data.packet_kind   = kind_byte;
    push_data.item_kind     = KIND_STATUS;

    if (take) begin
      case (op_t'(item.opcode))
        OP_ARM: begin
          phase_next              = PH_HEADER;
          position_next           = '0;
          header_first_bytes_next = '0;
          kind_byte_next          = '0;
          length_field_next       = '0;
          running_sum_next        = '0;
          checksum_high_next      = '0;
          accepted_len_next       = '0;
          time_left_next          = deadline_ms;
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (time_left <= 16'd1) begin
              time_left_next           = '0;
              phase_next               = PH_IDLE;
              push                     = 1'b1;
              push_data.status         = ST_TIMEOUT;
              push_data.payload_length = accepted_len;
            end else begin
              time_left_next = time_left - 16'd1;
            end
          end
        end
        OP_BYTE: begin
          case (phase)
            PH_HEADER: begin
              if (hpos < 4'd2) begin
                header_first_bytes_next = {header_first_bytes[7:0], item.byte_value};
              end else if (hpos == HdrKindPos) begin
                kind_byte_next = item.byte_value;
              end else if (hpos == HdrLenHiPos || hpos == HdrLastPos) begin
                length_field_next = len_full;
              end
              if (hpos != HdrLastPos) begin
                position_next = pos_inc;
              end else if (header_first_bytes != HdrSync) begin
                phase_next       = PH_IDLE;
                push             = 1'b1;
                push_data.status = ST_BAD_HDR;
              end else if (len_full < 16'd2) begin
                phase_next       = PH_IDLE;
                push             = 1'b1;
                push_data.status = ST_SHORT;
              end else if (len_pay > {6'd0, max_payload}) begin
                phase_next       = PH_IDLE;
                push             = 1'b1;
                push_data.status = ST_TOO_LONG;
              end else begin
                accepted_len_next = len_pay[LenW-1:0];
                running_sum_next  = {8'd0, kind_byte} + {8'd0, len_full[15:8]}
                                    + {8'd0, len_full[7:0]};
                position_next     = '0;
                phase_next        = (len_pay == 16'd0) ? PH_CK_HIGH : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              running_sum_next       = running_sum + {8'd0, item.byte_value};
              push                   = 1'b1;
              push_data.item_kind    = KIND_PAYLOAD;
              push_data.payload_byte = item.byte_value;
              push_data.byte_index   = position;
              push_data.status       = ST_OK;
              position_next          = pos_inc;
              if (pos_inc >= accepted_len) begin
                phase_next = PH_CK_HIGH;
              end
            end
            PH_CK_HIGH: begin
              checksum_high_next = item.byte_value;
              phase_next         = PH_CK_LOW;
            end
            PH_CK_LOW: begin
              phase_next               = PH_IDLE;
              push                     = 1'b1;
              push_data.payload_length = accepted_len;
              push_data.status = ({checksum_high, item.byte_value} == running_sum) ?
                                 ST_OK : ST_CK_BAD;
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/sensor_packet_deframer_unit.sv]
// Sensor packet deframer, top level.
// Channels: item (sink) takes requests with opcode 0 arm, 1 received UART
// byte, 2 one-millisecond tick. result (source) gives one payload item per
// payload byte (byte and index) and one status item that ends each packet
// (ok, bad header, length under two, too long, checksum mismatch, timeout).
// Configuration: cfg_we/cfg_idx/cfg_data, index 0 deadline in ms (sampled at
// arm), index 1 max_payload (sampled at header end); write while idle.
// Throughput: one request per cycle while item.ready is high. Each request is
// decoded by a single pass of compare/add logic against the state registers;
// its result is registered in the output register, or in skid if that is held.
// A two-entry output buffer (output register plus skid) decouples the
// sides: item.ready drops only when both entries are full, so a stalled
// receiver holds at most two results and no result is lost or repeated.
// Bytes and ticks while not armed are dropped without a result.
// Reset (rst, synchronous) returns to idle/not armed, empties the buffer,
// and loads a 2000 ms deadline and max_payload 64.
// Depends on spd_pkg, spd_item_if, spd_result_if, spd_core, spd_out_buf.
module sensor_packet_deframer_unit
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  spd_item_if.sink            item,
  spd_result_if.source        result
);

  logic    push;
  logic    space;
  result_t push_data;

  spd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .space     (space),
    .item      (item),
    .push      (push),
    .push_data (push_data)
  );

  spd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .result    (result)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sensor_packet_deframer_unit: framed UART traffic with an
// in-order deframer predictor, random stalls on both channels and register phases.
// Depends on spd_pkg, spd_item_if, spd_result_if and the RTL under rtl/.
module tb_top;
  import spd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 50;
  // arm-free frame: sync, zero address, id 0xFF, length 4, payload 00 FF, checksum 0x0202
  localparam logic [13*8-1:0] BOUNDARY_FRAME =
    {HdrSync, 32'h0, 8'hFF, 16'h0004, 8'h00, 8'hFF, 16'h0202};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } uart_req_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  spd_item_if   item_ch ();
  spd_result_if result_ch ();

  sensor_packet_deframer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  uart_req_t   uart_reqs[$];
  uart_req_t   on_bus;
  result_t     packet_results[$];
  result_t     want_result;
  int          useful_reqs = 0;
  int          reqs_taken = 0;
  int          send_gap_pct = 13;
  int          recv_gap_pct = 51;
  int          hold_at = -1;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  // deframer state as seen from outside
  logic [15:0]     timeout_reg = TimeoutReset;
  logic [LenW-1:0] max_len_reg = MaxPayloadReset;
  phase_t          rx_phase = PH_IDLE;
  logic [LenW-1:0] rx_pos = '0;
  logic [15:0]     sync_word = '0;
  logic [7:0]      id_byte = '0;
  logic [15:0]     len_word = '0;
  logic [15:0]     sum_word = '0;
  logic [7:0]      ck_hi = '0;
  logic [15:0]     ms_left = '0;
  logic [LenW-1:0] body_len = '0;

  function automatic void end_packet(status_t st, logic [LenW-1:0] plen);
    result_t r;
    r = '0;
    r.item_kind      = KIND_STATUS;
    r.status         = st;
    r.packet_kind    = id_byte;
    r.payload_length = plen;
    packet_results.push_back(r);
    rx_phase = PH_IDLE;
  endfunction

  function automatic void advance_deframer(logic [1:0] op, logic [7:0] b);
    result_t r;
    if (op == OP_ARM) begin
      rx_phase  = PH_HEADER;
      rx_pos    = '0;
      sync_word = '0;
      id_byte   = '0;
      len_word  = '0;
      sum_word  = '0;
      ck_hi     = '0;
      body_len  = '0;
      ms_left   = timeout_reg;
      return;
    end
    if (rx_phase == PH_IDLE || (op != OP_BYTE && op != OP_TICK)) return;
    if (op == OP_TICK) begin
      if (ms_left <= 16'd1) begin
        ms_left = '0;
        end_packet(ST_TIMEOUT, body_len);
      end else begin
        ms_left = ms_left - 16'd1;
      end
      return;
    end
    case (rx_phase)
      PH_HEADER: begin
        if (rx_pos < 2) sync_word = {sync_word[7:0], b};
        else if (rx_pos == HdrKindPos) id_byte = b;
        else if (rx_pos >= HdrLenHiPos) len_word = {len_word[7:0], b};
        if (rx_pos < HdrLastPos) begin
          rx_pos = rx_pos + LenW'(1);
        end else if (sync_word != HdrSync) begin
          end_packet(ST_BAD_HDR, '0);
        end else if (len_word < 16'd2) begin
          end_packet(ST_SHORT, '0);
        end else if (len_word - 16'd2 > {6'd0, max_len_reg}) begin
          end_packet(ST_TOO_LONG, '0);
        end else begin
          body_len = LenW'(len_word - 16'd2);
          sum_word = {8'd0, id_byte} + {8'd0, len_word[15:8]} + {8'd0, len_word[7:0]};
          rx_pos   = '0;
          rx_phase = (body_len == 0) ? PH_CK_HIGH : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_word = sum_word + {8'd0, b};
        r = '0;
        r.item_kind    = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = rx_pos;
        r.status       = ST_OK;
        r.packet_kind  = id_byte;
        packet_results.push_back(r);
        rx_pos = rx_pos + LenW'(1);
        if (rx_pos >= body_len) rx_phase = PH_CK_HIGH;
      end
      PH_CK_HIGH: begin
        ck_hi    = b;
        rx_phase = PH_CK_LOW;
      end
      PH_CK_LOW: begin
        end_packet(({ck_hi, b} != sum_word) ? ST_CK_BAD : ST_OK, body_len);
      end
      default: rx_phase = PH_IDLE;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp);
    if (got !== exp) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        advance_deframer(on_bus.op, on_bus.data);
        reqs_taken <= reqs_taken + 1;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (uart_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          on_bus = uart_reqs.pop_front();
          item_ch.valid      <= 1'b1;
          item_ch.opcode     <= on_bus.op;
          item_ch.byte_value <= on_bus.data;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (packet_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, kind %0d status %0d",
                                  result_ch.item_kind, result_ch.status));
        end else begin
          want_result = packet_results.pop_front();
          check_field("item_kind", 16'(result_ch.item_kind), 16'(want_result.item_kind));
          check_field("payload_byte", 16'(result_ch.payload_byte),
                      16'(want_result.payload_byte));
          check_field("byte_index", 16'(result_ch.byte_index),
                      16'(want_result.byte_index));
          check_field("status", 16'(result_ch.status), 16'(want_result.status));
          check_field("packet_kind", 16'(result_ch.packet_kind),
                      16'(want_result.packet_kind));
          check_field("payload_length", 16'(result_ch.payload_length),
                      16'(want_result.payload_length));
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // long receiver hold-off so the output buffer fills and input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_taken == hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] op, logic [7:0] data, bit counted);
    uart_req_t q;
    q.op   = op;
    q.data = data;
    uart_reqs.push_back(q);
    if (counted) useful_reqs++;
  endtask

  task automatic queue_frame(logic [15:0] len_field, bit bad_sync, bit bad_sum,
                             int cut_at, int tick_pct);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    logic [15:0] ck;
    int          sync_pos;
    bit          hdr_ok;
    bytes.push_back(HdrSync[15:8]);
    bytes.push_back(HdrSync[7:0]);
    if (bad_sync) begin
      sync_pos = $urandom_range(0, 1);
      bytes[sync_pos] = bytes[sync_pos] ^ (8'd1 << $urandom_range(0, 7));
    end
    repeat (5) bytes.push_back(8'($urandom));  // address and id
    bytes.push_back(len_field[15:8]);
    bytes.push_back(len_field[7:0]);
    hdr_ok = !bad_sync && len_field >= 16'd2 && len_field - 16'd2 <= {6'd0, max_len_reg};
    if (hdr_ok) begin
      ck = {8'd0, bytes[6]} + {8'd0, len_field[15:8]} + {8'd0, len_field[7:0]};
      repeat (int'(len_field) - 2) begin
        b = 8'($urandom);
        ck += {8'd0, b};
        bytes.push_back(b);
      end
      if (bad_sum) ck ^= 16'($urandom_range(1, 65535));
      bytes.push_back(ck[15:8]);
      bytes.push_back(ck[7:0]);
    end
    queue_req(OP_ARM, 8'($urandom), 1'b1);
    foreach (bytes[k]) begin
      if (k == cut_at) break;
      if ($urandom_range(0, 99) < tick_pct) queue_req(OP_TICK, 8'($urandom), 1'b1);
      queue_req(OP_BYTE, bytes[k], 1'b1);
    end
  endtask

  task automatic random_traffic(int budget, int tick_pct);
    int          goal;
    int          pick;
    int          cap;
    logic [15:0] lf;
    goal = useful_reqs + budget;
    while (useful_reqs < goal) begin
      pick = $urandom_range(0, 99);
      cap = (max_len_reg < 12) ? max_len_reg : 12;
      if ($urandom_range(0, 15) == 0) cap = (max_len_reg < 64) ? max_len_reg : 64;
      lf = 16'($urandom_range(0, cap) + 2);
      if (pick < 68) begin
        queue_frame(lf, 1'b0, 1'b0, -1, tick_pct);
      end else if (pick < 74) begin
        queue_frame(lf, 1'b0, 1'b1, -1, tick_pct);
      end else if (pick < 79) begin
        queue_frame($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                    1'b1, 1'b0, -1, tick_pct);
      end else if (pick < 83) begin
        queue_frame(16'($urandom_range(0, 1)), 1'b0, 1'b0, -1, tick_pct);
      end else if (pick < 88) begin
        queue_frame(16'($urandom_range(max_len_reg + 3,
                                       $urandom_range(0, 1) ? max_len_reg + 6 : 65535)),
                    1'b0, 1'b0, -1, tick_pct);
      end else if (pick < 95) begin
        queue_frame(lf, 1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, lf + 10), tick_pct);
      end else begin
        repeat ($urandom_range(1, 4))
          queue_req(2'($urandom_range(OP_BYTE, OP_UNUSED)), 8'($urandom), 1'b0);
      end
    end
    queue_frame(16'($urandom_range(2, 6)), 1'b0, 1'b0, -1, 0);  // leaves the unit idle
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (uart_reqs.size() != 0 || item_ch.valid || packet_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CFG_DEADLINE_MS) timeout_reg = data;
    else if (idx == CFG_MAX_PAYLOAD) max_len_reg = data[LenW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_DEADLINE_MS;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings; idle noise, arm during header, empty payload, byte extremes
    queue_req(OP_BYTE, 8'hFF, 1'b0);
    queue_req(OP_TICK, 8'h00, 1'b0);
    queue_req(OP_UNUSED, 8'hA5, 1'b0);
    queue_frame(16'd2, 1'b0, 1'b0, 2, 0);
    queue_frame(16'd2, 1'b0, 1'b0, -1, 0);
    queue_req(OP_ARM, 8'h00, 1'b1);
    for (int k = 12; k >= 0; k--) queue_req(OP_BYTE, BOUNDARY_FRAME[k*8 +: 8], 1'b1);
    random_traffic(100, 2);
    wait_quiet();

    // shortest deadline, no payload allowed
    write_reg(CFG_DEADLINE_MS, 16'd1);
    write_reg(CFG_MAX_PAYLOAD, 16'd0);
    queue_req(OP_ARM, 8'hFF, 1'b1);
    queue_req(OP_TICK, 8'hFF, 1'b1);
    random_traffic(40, 4);
    wait_quiet();

    send_gap_pct = 51;
    recv_gap_pct = 13;
    write_reg(CFG_DEADLINE_MS, 16'hFFFF);
    write_reg(CFG_MAX_PAYLOAD, 16'd1023);
    queue_frame(16'd1025, 1'b0, 1'b0, -1, 1);
    queue_frame(16'd1026, 1'b0, 1'b0, -1, 0);
    random_traffic(60, 5);
    wait_quiet();

    write_reg(CFG_DEADLINE_MS, 16'd5);
    write_reg(CFG_MAX_PAYLOAD, 16'd20);
    random_traffic(60, 12);
    wait_quiet();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(CFG_DEADLINE_MS, 16'd300);
    write_reg(CFG_MAX_PAYLOAD, 16'd100);
    hold_at = reqs_taken + 30;
    random_traffic(60, 1);
    wait_quiet();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
